// ===== design/bsu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsu_pkg
// Shared types and constants of the bucketed space-saving update block.
// ----------------------------------------------------------------------------
package bsu_pkg;

	localparam int CFG_WIDTH = 4;
	localparam logic [CFG_WIDTH-1:0] SLOTS_IN_USE_RESET = 4'd8;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_UPDATE
	} state_t;

	typedef enum logic [1:0] {
		ACT_HIT     = 2'd0,
		ACT_FILL    = 2'd1,
		ACT_REPLACE = 2'd2
	} action_t;

	typedef struct packed {
		logic [31:0]        flow_id;
		logic [7:0]         bucket_index;
		logic signed [31:0] light_unbiased_est;
		logic [31:0]        light_over_est;
	} in_word_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [2:0]  slot_index;
		logic [31:0] slot_count;
		logic        evicted_valid;
		logic [31:0] evicted_id;
		logic [31:0] evicted_weight;
	} out_word_t;

endpackage
`default_nettype wire

// ===== design/bsu_row_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsu_row_ram
// Single-port synchronous RAM holding one bucket row per word, registered read.
// ----------------------------------------------------------------------------
module bsu_row_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 1536,
	parameter int AW    = 8
) (
	input  wire logic             clk,
	input  wire logic             en,
	input  wire logic             we,
	input  wire logic [AW-1:0]    addr,
	input  wire logic [WIDTH-1:0] wdata,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule
`default_nettype wire

// ===== design/bsu_match.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsu_match
// Slot selection for one bucket row: first live id match, else first empty
// slot, else the first slot holding the smallest count.
// ----------------------------------------------------------------------------
module bsu_match #(
	parameter int SLOTS       = 8,
	parameter int COUNT_WIDTH = 32,
	parameter int NW          = 4,
	parameter int SELW        = 3
) (
	input  wire logic                               clk,
	input  wire logic                               load,
	input  wire logic [31:0]                        flow_id,
	input  wire logic [NW-1:0]                      n_eff,
	input  wire logic [SLOTS-1:0][31:0]             row_id,
	input  wire logic [SLOTS-1:0][COUNT_WIDTH-1:0]  row_cnt,
	input  wire logic [SLOTS-1:0][COUNT_WIDTH-1:0]  row_und,
	output bsu_pkg::action_t                        action,
	output logic [SELW-1:0]                         sel
);

	localparam int GROUPS = (SLOTS + 3) / 4;

	logic                                hit_c, empty_c;
	logic [SELW-1:0]                     hit_sel_c, empty_sel_c;
	logic [GROUPS-1:0]                   gok_c;
	logic [GROUPS-1:0][COUNT_WIDTH-1:0]  gmin_c;
	logic [GROUPS-1:0][SELW-1:0]         gsel_c;

	logic                                hit_s1, empty_s1;
	logic [SELW-1:0]                     hit_sel_s1, empty_sel_s1;
	logic [GROUPS-1:0]                   gok_s1;
	logic [GROUPS-1:0][COUNT_WIDTH-1:0]  gmin_s1;
	logic [GROUPS-1:0][SELW-1:0]         gsel_s1;

	logic                                found;
	logic [COUNT_WIDTH-1:0]              best;
	logic [SELW-1:0]                     best_sel;

	// Priority searches run high to low so the lowest slot wins.
	always_comb begin
		hit_c       = 1'b0;
		hit_sel_c   = '0;
		empty_c     = 1'b0;
		empty_sel_c = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (NW'(i) < n_eff) begin
				if (row_id[i] == flow_id && row_und[i] != '0) begin
					hit_c     = 1'b1;
					hit_sel_c = SELW'(i);
				end
				if (row_cnt[i] == '0) begin
					empty_c     = 1'b1;
					empty_sel_c = SELW'(i);
				end
			end
		end
	end

	// First half of the minimum tree: a running minimum within each group of four.
	always_comb begin
		gok_c  = '0;
		gmin_c = '0;
		gsel_c = '0;
		for (int i = 0; i < SLOTS; i++) begin
			if (NW'(i) < n_eff) begin
				if (!gok_c[i/4] || row_cnt[i] < gmin_c[i/4]) begin
					gok_c[i/4]  = 1'b1;
					gmin_c[i/4] = row_cnt[i];
					gsel_c[i/4] = SELW'(i);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			hit_s1       <= hit_c;
			hit_sel_s1   <= hit_sel_c;
			empty_s1     <= empty_c;
			empty_sel_s1 <= empty_sel_c;
			gok_s1       <= gok_c;
			gmin_s1      <= gmin_c;
			gsel_s1      <= gsel_c;
		end
	end

	always_comb begin
		found    = 1'b0;
		best     = '0;
		best_sel = '0;
		for (int g = 0; g < GROUPS; g++) begin
			if (gok_s1[g] && (!found || gmin_s1[g] < best)) begin
				found    = 1'b1;
				best     = gmin_s1[g];
				best_sel = gsel_s1[g];
			end
		end
	end

	always_comb begin
		if (hit_s1) begin
			action = bsu_pkg::ACT_HIT;
			sel    = hit_sel_s1;
		end else if (empty_s1) begin
			action = bsu_pkg::ACT_FILL;
			sel    = empty_sel_s1;
		end else begin
			action = bsu_pkg::ACT_REPLACE;
			sel    = best_sel;
		end
	end

endmodule
`default_nettype wire

// ===== design/bucketed_space_saving_update.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bucketed_space_saving_update
// Space-saving top-k update over a table of buckets with a row of slots each.
// ----------------------------------------------------------------------------
// Each word is handled in steps: the bucket row is read from a single-port row
// memory in the accept cycle, the slots are compared in the next (first half of
// the minimum tree registered there), and the selected slot is then updated and
// written back, with its result registered for the output at the write-back. A
// result waits in an output register; the following word is accepted while it
// waits, but its write-back holds until that result is taken. After reset the
// block sweeps the memory to zero, one bucket per cycle, and no word is accepted
// until the sweep ends; configuration writes are taken at any time.
module bucketed_space_saving_update #(
	parameter int BUCKETS     = 256,
	parameter int SLOTS       = 8,
	parameter int COUNT_WIDTH = 32
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire bsu_pkg::in_word_t                 in_data,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output bsu_pkg::out_word_t                     out_data,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [bsu_pkg::CFG_WIDTH-1:0]     cfg_data
);

	localparam int AW     = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int SELW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int NW     = $clog2(SLOTS + 1);
	localparam int CW     = COUNT_WIDTH;
	localparam int RW     = SLOTS * (96 + 2 * CW);
	localparam int RECIP  = (65536 + BUCKETS - 1) / BUCKETS;

	bsu_pkg::state_t   state_q, state_d;
	logic [AW-1:0]     clr_q;
	logic [bsu_pkg::CFG_WIDTH-1:0] slots_q;
	bsu_pkg::in_word_t item_q;
	logic [AW-1:0]     bucket_addr_q;
	logic              out_valid_q;
	bsu_pkg::out_word_t out_q;

	logic              mem_en, mem_we;
	logic [AW-1:0]     mem_addr;
	logic [RW-1:0]     mem_wdata, mem_rdata;

	logic [SLOTS-1:0][31:0] r_id, r_unb, r_ovr, n_id, n_unb, n_ovr;
	logic [SLOTS-1:0][CW-1:0] r_cnt, r_und, n_cnt, n_und;

	logic [NW-1:0]     n_eff;
	logic [4:0]        slots_ext;
	bsu_pkg::action_t  act;
	logic [SELW-1:0]   sel;
	logic [4:0]        sel_ext;

	logic [24:0]       prod, quot_b, rem_raw, rem;
	logic [7:0]        quot;
	logic [AW-1:0]     bucket_addr;

	logic              accept, take_out, do_update;
	bsu_pkg::out_word_t out_d;

	function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
		return (v == '1) ? v : v + CW'(1);
	endfunction

	function automatic logic [31:0] clip32(input logic [CW-1:0] v);
		logic [63:0] w;
		w = 64'(v);
		return (w > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : w[31:0];
	endfunction

	// Bucket modulo by a reciprocal multiply; exact for 8-bit inputs, the
	// final compare only guards the bound.
	always_comb begin
		prod    = 25'(in_data.bucket_index) * 25'(RECIP);
		quot    = prod[23:16];
		quot_b  = 25'(quot) * 25'(BUCKETS);
		rem_raw = 25'(in_data.bucket_index) - quot_b;
		rem     = (rem_raw >= 25'(BUCKETS)) ? rem_raw - 25'(BUCKETS) : rem_raw;
		bucket_addr = AW'(rem);
	end

	always_comb begin
		slots_ext = 5'(slots_q);
		if (slots_ext == 5'd0) begin
			n_eff = NW'(1);
		end else if (slots_ext > 5'(SLOTS)) begin
			n_eff = NW'(SLOTS);
		end else begin
			n_eff = NW'(slots_ext);
		end
	end

	assign {r_ovr, r_unb, r_und, r_cnt, r_id} = mem_rdata;

	bsu_row_ram #(
		.DEPTH (BUCKETS),
		.WIDTH (RW),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.en    (mem_en),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	bsu_match #(
		.SLOTS       (SLOTS),
		.COUNT_WIDTH (CW),
		.NW          (NW),
		.SELW        (SELW)
	) u_match (
		.clk     (clk),
		.load    (state_q == bsu_pkg::ST_READ),
		.flow_id (item_q.flow_id),
		.n_eff   (n_eff),
		.row_id  (r_id),
		.row_cnt (r_cnt),
		.row_und (r_und),
		.action  (act),
		.sel     (sel)
	);

	// New row contents and the result word for the selected slot.
	always_comb begin
		n_id  = r_id;
		n_cnt = r_cnt;
		n_und = r_und;
		n_unb = r_unb;
		n_ovr = r_ovr;
		out_d = '0;
		case (act)
			bsu_pkg::ACT_HIT: begin
				n_cnt[sel] = sat_inc(r_cnt[sel]);
				n_und[sel] = sat_inc(r_und[sel]);
			end
			bsu_pkg::ACT_FILL: begin
				n_cnt[sel] = CW'(1);
				n_id[sel]  = item_q.flow_id;
				n_und[sel] = CW'(1);
				n_unb[sel] = item_q.light_unbiased_est;
				n_ovr[sel] = item_q.light_over_est;
			end
			bsu_pkg::ACT_REPLACE: begin
				n_cnt[sel] = sat_inc(r_cnt[sel]);
				n_id[sel]  = item_q.flow_id;
				n_und[sel] = CW'(1);
				n_unb[sel] = item_q.light_unbiased_est;
				n_ovr[sel] = item_q.light_over_est;
				out_d.evicted_valid  = 1'b1;
				out_d.evicted_id     = r_id[sel];
				out_d.evicted_weight = clip32(r_und[sel]);
			end
			default: begin
			end
		endcase
		sel_ext          = 5'(sel);
		out_d.action     = act;
		out_d.slot_index = sel_ext[2:0];
		out_d.slot_count = clip32(n_cnt[sel]);
	end

	assign take_out = out_valid_q && out_ready;

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		accept    = 1'b0;
		do_update = 1'b0;
		mem_en    = 1'b0;
		mem_we    = 1'b0;
		mem_addr  = bucket_addr;
		mem_wdata = {n_ovr, n_unb, n_und, n_cnt, n_id};
		case (state_q)
			bsu_pkg::ST_CLEAR: begin
				mem_en    = 1'b1;
				mem_we    = 1'b1;
				mem_addr  = clr_q;
				mem_wdata = '0;
				if (clr_q == AW'(BUCKETS - 1)) begin
					state_d = bsu_pkg::ST_IDLE;
				end
			end
			bsu_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					accept  = 1'b1;
					mem_en  = 1'b1;
					state_d = bsu_pkg::ST_READ;
				end
			end
			bsu_pkg::ST_READ: begin
				state_d = bsu_pkg::ST_UPDATE;
			end
			bsu_pkg::ST_UPDATE: begin
				// The output register must be free before the row is committed.
				if (!out_valid_q || out_ready) begin
					do_update = 1'b1;
					mem_en    = 1'b1;
					mem_we    = 1'b1;
					mem_addr  = bucket_addr_q;
					state_d   = bsu_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = bsu_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bsu_pkg::ST_CLEAR;
			clr_q       <= '0;
			slots_q     <= bsu_pkg::SLOTS_IN_USE_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == bsu_pkg::ST_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (cfg_valid) begin
				slots_q <= cfg_data;
			end
			if (do_update) begin
				out_valid_q <= 1'b1;
			end else if (take_out) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q        <= in_data;
			bucket_addr_q <= bucket_addr;
		end
		if (do_update) begin
			out_q <= out_d;
		end
	end

	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
`default_nettype wire

// ===== verif/topk_update_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// topk_update_checker
// Watches the word, result and configuration channels of the bucketed
// space-saving update block. It keeps its own copy of the bucket table and
// predicts the result of every accepted word. Each accepted result is
// compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module topk_update_checker #(
	parameter int BUCKETS = 256,
	parameter int SLOTS   = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  bsu_pkg::in_word_t             in_data,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  bsu_pkg::out_word_t            out_data,
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic [bsu_pkg::CFG_WIDTH-1:0] cfg_data,
	output int                            errors,
	output int                            pending,
	output int                            hits,
	output int                            fills,
	output int                            replaces
);

	localparam int ROWS = BUCKETS * SLOTS;
	localparam int MAX_REPORTS = 200;

	logic [31:0]                   tag_mem [ROWS];
	logic [31:0]                   cnt_mem [ROWS];
	logic [31:0]                   uest_mem [ROWS];
	logic [bsu_pkg::CFG_WIDTH-1:0] slots_cfg;
	bsu_pkg::out_word_t            expected_updates [$];

	function automatic logic [31:0] sat_inc(logic [31:0] v);
		return (v == '1) ? v : v + 32'd1;
	endfunction

	// Applies one word to the table copy and returns the result it must cause.
	function automatic bsu_pkg::out_word_t predict_update(bsu_pkg::in_word_t w);
		int                 base;
		int                 n;
		int                 sel;
		bit                 found;
		bsu_pkg::out_word_t r;
		r = '0;
		n = (slots_cfg == 0) ? 1 : (slots_cfg > SLOTS) ? SLOTS : int'(slots_cfg);
		base = (int'(w.bucket_index) % BUCKETS) * SLOTS;
		found = 1'b0;
		sel = 0;
		for (int j = 0; j < n; j++) begin
			if (!found && tag_mem[base + j] == w.flow_id && uest_mem[base + j] != 0) begin
				found = 1'b1;
				sel = j;
			end
		end
		if (found) begin
			cnt_mem[base + sel] = sat_inc(cnt_mem[base + sel]);
			uest_mem[base + sel] = sat_inc(uest_mem[base + sel]);
			r.action = bsu_pkg::ACT_HIT;
		end else begin
			for (int j = 0; j < n; j++) begin
				if (!found && cnt_mem[base + j] == 0) begin
					found = 1'b1;
					sel = j;
				end
			end
			if (found) begin
				cnt_mem[base + sel] = 32'd1;
				r.action = bsu_pkg::ACT_FILL;
			end else begin
				// Strict less-than keeps the lowest slot on a tie.
				sel = 0;
				for (int j = 1; j < n; j++) begin
					if (cnt_mem[base + j] < cnt_mem[base + sel])
						sel = j;
				end
				cnt_mem[base + sel] = sat_inc(cnt_mem[base + sel]);
				r.action = bsu_pkg::ACT_REPLACE;
				r.evicted_valid = 1'b1;
				r.evicted_id = tag_mem[base + sel];
				r.evicted_weight = uest_mem[base + sel];
			end
			tag_mem[base + sel] = w.flow_id;
			uest_mem[base + sel] = 32'd1;
		end
		r.slot_index = sel[2:0];
		r.slot_count = cnt_mem[base + sel];
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			errors++;
			if (errors <= MAX_REPORTS)
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		bsu_pkg::out_word_t want;
		if (!arst_n) begin
			for (int k = 0; k < ROWS; k++) begin
				tag_mem[k] = '0;
				cnt_mem[k] = '0;
				uest_mem[k] = '0;
			end
			expected_updates.delete();
			slots_cfg = bsu_pkg::SLOTS_IN_USE_RESET;
			errors = 0;
			hits = 0;
			fills = 0;
			replaces = 0;
		end else begin
			// A result can never belong to a word accepted at the same edge.
			if (out_valid && out_ready) begin
				if (expected_updates.size() == 0) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("%0t: result with nothing expected, expected none, actual %0h",
							$time, out_data);
				end else begin
					want = expected_updates.pop_front();
					check_field("action", 32'(want.action), 32'(out_data.action));
					check_field("slot_index", 32'(want.slot_index), 32'(out_data.slot_index));
					check_field("slot_count", want.slot_count, out_data.slot_count);
					check_field("evicted_valid", 32'(want.evicted_valid),
						32'(out_data.evicted_valid));
					check_field("evicted_id", want.evicted_id, out_data.evicted_id);
					check_field("evicted_weight", want.evicted_weight, out_data.evicted_weight);
					case (bsu_pkg::action_t'(want.action))
						bsu_pkg::ACT_HIT:     hits++;
						bsu_pkg::ACT_FILL:    fills++;
						bsu_pkg::ACT_REPLACE: replaces++;
						default: ;
					endcase
				end
			end
			if (in_valid && in_ready)
				expected_updates.push_back(predict_update(in_data));
			if (cfg_valid && cfg_ready)
				slots_cfg = cfg_data;
		end
		pending = expected_updates.size();
	end

endmodule

// ===== verif/bucketed_space_saving_update_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bucketed_space_saving_update_test
// Drives words into the bucketed space-saving update block: a directed
// opening that fills, hits and replaces slots, then random phases under
// several slot counts, with random idling on both channels.
// ----------------------------------------------------------------------------
module bucketed_space_saving_update_test;

	localparam int LIMIT = 500000;
	localparam int PHASES = 8;
	localparam int PHASE_WORDS = 174;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          in_valid = 1'b0;
	logic                          in_ready;
	bsu_pkg::in_word_t             in_data = '0;
	logic                          out_valid;
	logic                          out_ready = 1'b1;
	bsu_pkg::out_word_t            out_data;
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic [bsu_pkg::CFG_WIDTH-1:0] cfg_data = '0;

	int errors;
	int pending;
	int hits;
	int fills;
	int replaces;
	int cycles = 0;
	int words_sent = 0;
	bit calm = 1'b0;

	// Zero and fifteen exercise the clamping of the slot count at both ends.
	logic [bsu_pkg::CFG_WIDTH-1:0] slot_settings [PHASES] =
		'{4'd0, 4'd15, 4'd1, 4'd3, 4'd8, 4'd5, 4'd2, 4'd7};
	logic [7:0] hot_bucket [4] = '{8'hFF, 8'h00, 8'h11, 8'hC8};

	always #10 clk = ~clk;

	bucketed_space_saving_update DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	topk_update_checker update_check (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.errors   (errors),
		.pending  (pending),
		.hits     (hits),
		.fills    (fills),
		.replaces (replaces)
	);

	// Result side stalls in bursts; none once the run turns calm.
	always begin
		@(negedge clk);
		if (!calm && $urandom_range(0, 7) == 0) begin
			out_ready <= 1'b0;
			repeat ($urandom_range(1, 15)) @(negedge clk);
		end
		out_ready <= 1'b1;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("bucketed_space_saving_update test failed");
			$finish;
		end
	end

	function automatic bsu_pkg::in_word_t mk_word(logic [31:0] id, logic [7:0] bucket,
		logic [31:0] unb, logic [31:0] ovr);
		bsu_pkg::in_word_t w;
		w.flow_id = id;
		w.bucket_index = bucket;
		w.light_unbiased_est = signed'(unb);
		w.light_over_est = ovr;
		return w;
	endfunction

	task automatic send_word(input bsu_pkg::in_word_t w);
		@(negedge clk);
		if (!calm && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(negedge clk);
		end
		in_data <= w;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		words_sent++;
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	task automatic write_slots(input logic [bsu_pkg::CFG_WIDTH-1:0] value);
		@(negedge clk);
		cfg_data <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int          r;
		logic [31:0] id;
		logic [7:0]  bucket;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		// Fill one bucket completely, with extreme estimates.
		for (int k = 1; k <= 8; k++)
			send_word(mk_word(k, 8'hFF, (k % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF,
				(k % 2) ? 32'hFFFF_FFFF : 32'h0));
		send_word(mk_word(32'd3, 8'hFF, 32'h0, 32'h1));
		send_word(mk_word(32'd3, 8'hFF, 32'hFFFF_FFFF, 32'h8000_0000));
		// Full bucket: replacements take the lowest slot among equal minimums.
		send_word(mk_word(32'd100, 8'hFF, 32'h1, 32'h2));
		send_word(mk_word(32'd101, 8'hFF, 32'h3, 32'h4));
		send_word(mk_word(32'd100, 8'hFF, 32'h5, 32'h6));
		// Id zero must not match an empty slot, whose stored id is also zero.
		send_word(mk_word(32'h0, 8'h00, 32'h0, 32'h0));
		send_word(mk_word(32'h0, 8'h00, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
		send_word(mk_word(32'hFFFF_FFFF, 8'h00, 32'h8000_0000, 32'h0));
		send_word(mk_word(32'h5A5A_5A5A, 8'h80, 32'h1234_5678, 32'h9ABC_DEF0));
		send_word(mk_word(32'hA5A5_A5A5, 8'h80, 32'hEDCB_A987, 32'h6543_210F));

		for (int p = 0; p < PHASES; p++) begin
			drain();
			write_slots(slot_settings[p]);
			if (p == PHASES - 1)
				calm = 1'b1;
			for (int i = 0; i < PHASE_WORDS; i++) begin
				// Mostly a few hot buckets and a small id pool, so hits and
				// replacements dominate; the rest is fully random.
				r = $urandom_range(0, 99);
				bucket = (r < 80) ? hot_bucket[$urandom_range(0, 3)] : 8'($urandom);
				r = $urandom_range(0, 99);
				if (r < 45)
					id = $urandom_range(0, 4);
				else if (r < 80)
					id = $urandom_range(0, 15);
				else
					id = $urandom;
				send_word(mk_word(id, bucket, $urandom, $urandom));
			end
		end

		drain();
		repeat (10) @(negedge clk);
		$display("Sent %0d words under %0d slot settings after the directed opening.",
			words_sent, PHASES);
		$display("Checked %0d hits, %0d fills and %0d replacements.", hits, fills, replaces);
		if (errors == 0 && pending == 0)
			$display("bucketed_space_saving_update test passed");
		else
			$display("bucketed_space_saving_update test failed");
		$finish;
	end

endmodule

// ===== sim.f =====
design/bsu_pkg.sv
design/bsu_row_ram.sv
design/bsu_match.sv
design/bucketed_space_saving_update.sv
verif/topk_update_checker.sv
verif/bucketed_space_saving_update_test.sv
